/* hw/rtl/sem_pkg.sv */
// ----------------------------------------------------------------------------
// sem_pkg
// Shared widths, register map and stage control types for the Sobel edge
// magnitude unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

  // Line store geometry
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);   // column index
  localparam int ROW_W      = $clog2(MAX_HEIGHT);  // output row index

  // Field and register widths
  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 13;
  localparam int INROW_W  = 13;   // input row runs one or two rows past the frame

  // Configuration register map (register index taken from paddr[2])
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  // Border and emit flags that travel with one pixel down the pipeline
  typedef struct packed {
    logic emit;     // pixel completes a window that yields a result
    logic last;     // result is the final pixel of the frame
    logic left;     // output pixel sits in column 0
    logic right;    // output pixel sits in the last column
    logic top;      // output pixel sits in row 0
    logic bottom;   // output pixel sits in the last row
  } sem_pos_t;

endpackage

`default_nettype wire

/* hw/rtl/sobel_edge_magnitude_unit.sv */
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_unit
// Streaming 3x3 Sobel edge detector with zero padding and clamped outputs.
// ----------------------------------------------------------------------------
// Throughput: one pixel per clock while the output is not stalled; the line store's separate
//   read and write ports each handle one column per cycle, with forwarding for one-pixel rows.
// Pipeline: a result reaches the output register through the stage 1 registers, the window and
//   the s2 registers after the transfer of the pixel that completes its window (one row plus one pixel later).
// Reset: counters, window and pipeline valids clear; width 640, height 480.
//   Line store contents stay undefined and no clearing pass is run.
`default_nettype none

module sobel_edge_magnitude_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // pixel input channel
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [sem_pkg::PIX_W-1:0]   pixel,
  input  wire logic                        is_pad,
  // result output channel
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [sem_pkg::PIX_W-1:0]        horiz_gradient,
  output logic [sem_pkg::PIX_W-1:0]        vert_gradient,
  output logic [sem_pkg::PIX_W-1:0]        magnitude,
  output logic                             frame_last,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [sem_pkg::WIDTH_W-1:0]  cfg_width;
  logic [sem_pkg::HEIGHT_W-1:0] cfg_height;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= sem_pkg::WIDTH_RESET;
      cfg_height <= sem_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        sem_pkg::REG_IMAGE_WIDTH:  cfg_width  <= pwdata[sem_pkg::WIDTH_W-1:0];
        sem_pkg::REG_IMAGE_HEIGHT: cfg_height <= pwdata[sem_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sem_pkg::REG_IMAGE_WIDTH:  prdata = {{(32-sem_pkg::WIDTH_W){1'b0}}, cfg_width};
      sem_pkg::REG_IMAGE_HEIGHT: prdata = {{(32-sem_pkg::HEIGHT_W){1'b0}}, cfg_height};
      default:                   prdata = '0;
    endcase
  end

  // Effective frame size: zero acts as one, oversize acts as the maximum
  logic [sem_pkg::WIDTH_W-1:0]  w_eff;
  logic [sem_pkg::HEIGHT_W-1:0] h_eff;
  logic [sem_pkg::COL_W-1:0]    w_last;
  logic [sem_pkg::ROW_W-1:0]    h_last;
  logic [sem_pkg::WIDTH_W-1:0]  w_dec;
  logic [sem_pkg::HEIGHT_W-1:0] h_dec;

  always_comb begin
    priority if (cfg_width == '0)
      w_eff = sem_pkg::WIDTH_W'(1);
    else if (cfg_width > sem_pkg::WIDTH_W'(sem_pkg::MAX_WIDTH))
      w_eff = sem_pkg::WIDTH_W'(sem_pkg::MAX_WIDTH);
    else
      w_eff = cfg_width;
    priority if (cfg_height == '0)
      h_eff = sem_pkg::HEIGHT_W'(1);
    else if (cfg_height > sem_pkg::HEIGHT_W'(sem_pkg::MAX_HEIGHT))
      h_eff = sem_pkg::HEIGHT_W'(sem_pkg::MAX_HEIGHT);
    else
      h_eff = cfg_height;
    w_dec  = w_eff - sem_pkg::WIDTH_W'(1);
    h_dec  = h_eff - sem_pkg::HEIGHT_W'(1);
    w_last = w_dec[sem_pkg::COL_W-1:0];
    h_last = h_dec[sem_pkg::ROW_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: the whole pipe moves unless the held result is stalled
  // --------------------------------------------------------------------------
  logic adv;
  logic in_xfer;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign in_xfer  = in_valid && adv;

  // --------------------------------------------------------------------------
  // Stage 0: position counters, pad filter, border flags
  // --------------------------------------------------------------------------
  logic [sem_pkg::COL_W-1:0]   in_col,  in_col_next;
  logic [sem_pkg::INROW_W-1:0] in_row,  in_row_next;
  logic [sem_pkg::COL_W-1:0]   out_col, out_col_next;
  logic [sem_pkg::ROW_W-1:0]   out_row, out_row_next;
  logic                        in_frame;
  logic                        take;
  logic [sem_pkg::PIX_W-1:0]   pix_eff;
  sem_pkg::sem_pos_t           pos;

  always_comb begin
    in_frame = in_row < sem_pkg::INROW_W'(h_eff);
    // a pad inside the frame is dropped; after the frame every item flushes
    take     = in_xfer && !(in_frame && is_pad);
    pix_eff  = in_frame ? pixel : '0;

    pos.emit   = (in_row >= sem_pkg::INROW_W'(2)) ||
                 ((in_row == sem_pkg::INROW_W'(1)) && (in_col != '0));
    pos.left   = (out_col == '0);
    pos.right  = (out_col == w_last);
    pos.top    = (out_row == '0);
    pos.bottom = (out_row == h_last);
    pos.last   = pos.emit && pos.right && pos.bottom;

    // advance input raster position
    if (in_col == w_last) begin
      in_col_next = '0;
      in_row_next = in_row + sem_pkg::INROW_W'(1);
    end else begin
      in_col_next = in_col + sem_pkg::COL_W'(1);
      in_row_next = in_row;
    end

    // advance output raster position
    out_col_next = out_col;
    out_row_next = out_row;
    if (pos.emit) begin
      if (pos.right) begin
        out_col_next = '0;
        out_row_next = out_row + sem_pkg::ROW_W'(1);
      end else begin
        out_col_next = out_col + sem_pkg::COL_W'(1);
      end
    end

    // final result of the frame restarts all counters
    if (pos.last) begin
      in_col_next  = '0;
      in_row_next  = '0;
      out_col_next = '0;
      out_row_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (take) begin
      in_col  <= in_col_next;
      in_row  <= in_row_next;
      out_col <= out_col_next;
      out_row <= out_row_next;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: one entry per column, {upper row, lower row}
  // --------------------------------------------------------------------------
  logic [2*sem_pkg::PIX_W-1:0] line_mem [sem_pkg::MAX_WIDTH];
  logic [2*sem_pkg::PIX_W-1:0] mem_q;
  logic [2*sem_pkg::PIX_W-1:0] fwd_data;
  logic [2*sem_pkg::PIX_W-1:0] rd_data;
  logic [2*sem_pkg::PIX_W-1:0] wr_data;

  // Stage 1 registers
  logic                        s1_valid;
  logic                        s1_fwd;
  logic [sem_pkg::COL_W-1:0]   s1_col;
  logic [sem_pkg::PIX_W-1:0]   s1_pix;
  sem_pkg::sem_pos_t           s1_pos;

  // read port: address issued at transfer, data registered
  always_ff @(posedge clk) begin
    if (adv) begin
      mem_q <= line_mem[in_col];
    end
  end

  // write port: stage 1 writes back the shifted column
  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      line_mem[s1_col] <= wr_data;
    end
  end

  // bypass the column the previous pixel is writing in the same cycle
  assign rd_data = s1_fwd ? fwd_data : mem_q;
  assign wr_data = {rd_data[sem_pkg::PIX_W-1:0], s1_pix};

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      fwd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_fwd   <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
      s1_fwd   <= take && s1_valid && (s1_col == in_col);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col <= in_col;
      s1_pix <= pix_eff;
      s1_pos <= pos;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: shift the 3x3 window (left, center, right columns; top to bottom)
  // --------------------------------------------------------------------------
  logic [sem_pkg::PIX_W-1:0] win [9];
  logic                      s2_valid;
  sem_pkg::sem_pos_t         s2_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (adv && s1_valid) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= win[i+3];
      end
      win[6] <= rd_data[2*sem_pkg::PIX_W-1:sem_pkg::PIX_W];
      win[7] <= rd_data[sem_pkg::PIX_W-1:0];
      win[8] <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid && s1_pos.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pos <= s1_pos;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: masked kernels, magnitude, clamp
  // --------------------------------------------------------------------------
  logic [sem_pkg::PIX_W-1:0] p [9];
  logic [9:0]                sum_r, sum_l, sum_t, sum_b;
  logic signed [11:0]        gx, gy;
  logic [10:0]               ax, ay;
  logic [11:0]               mag_sum;
  logic [sem_pkg::PIX_W-1:0] gx_c, gy_c, mag_c;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = win[i];
    end
    // zero the taps that fall outside the frame
    if (s2_pos.left) begin
      p[0] = '0; p[1] = '0; p[2] = '0;
    end
    if (s2_pos.right) begin
      p[6] = '0; p[7] = '0; p[8] = '0;
    end
    if (s2_pos.top) begin
      p[0] = '0; p[3] = '0; p[6] = '0;
    end
    if (s2_pos.bottom) begin
      p[2] = '0; p[5] = '0; p[8] = '0;
    end

    sum_r = {2'b00, p[6]} + {1'b0, p[7], 1'b0} + {2'b00, p[8]};
    sum_l = {2'b00, p[0]} + {1'b0, p[1], 1'b0} + {2'b00, p[2]};
    sum_t = {2'b00, p[0]} + {1'b0, p[3], 1'b0} + {2'b00, p[6]};
    sum_b = {2'b00, p[2]} + {1'b0, p[5], 1'b0} + {2'b00, p[8]};

    gx = $signed({2'b00, sum_r}) - $signed({2'b00, sum_l});
    gy = $signed({2'b00, sum_t}) - $signed({2'b00, sum_b});

    ax = gx[11] ? 11'(-gx) : gx[10:0];
    ay = gy[11] ? 11'(-gy) : gy[10:0];
    mag_sum = {1'b0, ax} + {1'b0, ay};

    // clamp to 0..255
    if (gx[11])
      gx_c = '0;
    else if (gx[10:8] != '0)
      gx_c = '1;
    else
      gx_c = gx[7:0];
    if (gy[11])
      gy_c = '0;
    else if (gy[10:8] != '0)
      gy_c = '1;
    else
      gy_c = gy[7:0];
    mag_c = (mag_sum[11:8] != '0) ? '1 : mag_sum[7:0];
  end

  // --------------------------------------------------------------------------
  // Output register: hold while stalled
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      horiz_gradient <= gx_c;
      vert_gradient  <= gy_c;
      magnitude      <= mag_c;
      frame_last     <= s2_pos.last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_in_col_range: assert property (@(posedge clk) disable iff (rst)
    in_col <= w_last)
    else $error("input column beyond row width");

  a_out_col_range: assert property (@(posedge clk) disable iff (rst)
    out_col <= w_last)
    else $error("output column beyond row width");

  a_last_at_corner: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_pos.last |-> s2_pos.right && s2_pos.bottom)
    else $error("frame end flagged away from bottom right corner");

  a_fwd_follows_write: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_fwd |-> $past(s1_valid))
    else $error("bypass selected with no preceding line store write");

endmodule

`default_nettype wire

/* test/tb_sobel_edge_magnitude_unit.sv */
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_unit
// Self-checking bench for the streaming 3x3 Sobel edge magnitude unit.
// A queue-fed driver streams raster frames with pad noise and flush ticks.
// A monitor compares every result against an in-bench line-store predictor.
// Frame geometry is reprogrammed over APB between idle phases, covering
// tiny and out-of-range frames under random input gaps and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude_unit;

  typedef struct {
    logic [sem_pkg::PIX_W-1:0] pix;
    logic                      pad;
  } pixel_item_t;

  typedef struct packed {
    logic [sem_pkg::PIX_W-1:0] horiz;
    logic [sem_pkg::PIX_W-1:0] vert;
    logic [sem_pkg::PIX_W-1:0] mag;
    logic                      last;
  } edge_result_t;

  // DUT connections
  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [sem_pkg::PIX_W-1:0] pixel     = '0;
  logic                      is_pad    = 1'b0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [sem_pkg::PIX_W-1:0] horiz_gradient;
  logic [sem_pkg::PIX_W-1:0] vert_gradient;
  logic [sem_pkg::PIX_W-1:0] magnitude;
  logic                      frame_last;
  logic                      psel      = 1'b0;
  logic                      penable   = 1'b0;
  logic                      pwrite    = 1'b0;
  logic [2:0]                paddr     = '0;
  logic [31:0]               pwdata    = '0;
  logic [31:0]               prdata;
  logic                      pready;

  // Stimulus and scoreboard storage
  pixel_item_t  pending_pixels[$];
  edge_result_t expected_edges[$];
  int           mismatch_count = 0;
  int unsigned  stim_count     = 0;
  bit           idling         = 1'b1;
  bit           in_taken       = 1'b0;
  int           in_gap_left    = 0;
  int           out_stall_left = 0;
  int unsigned  frame_w;
  int unsigned  frame_h;

  // Predictor state
  logic [sem_pkg::WIDTH_W-1:0]  cfg_width  = sem_pkg::WIDTH_RESET;
  logic [sem_pkg::HEIGHT_W-1:0] cfg_height = sem_pkg::HEIGHT_RESET;
  logic [sem_pkg::PIX_W-1:0]    upper_line [sem_pkg::MAX_WIDTH];
  logic [sem_pkg::PIX_W-1:0]    lower_line [sem_pkg::MAX_WIDTH];
  logic [sem_pkg::PIX_W-1:0]    win [9];   // left, center, right columns; top..bottom each
  int unsigned                  col_in     = 0;
  int unsigned                  row_in     = 0;
  int unsigned                  out_count  = 0;

  sobel_edge_magnitude_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel          (pixel),
    .is_pad         (is_pad),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .horiz_gradient (horiz_gradient),
    .vert_gradient  (vert_gradient),
    .magnitude      (magnitude),
    .frame_last     (frame_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the stream hangs
  initial begin
    #(10_000_000);
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [sem_pkg::PIX_W-1:0] sat_u8(input int v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return v[sem_pkg::PIX_W-1:0];
  endfunction

  function automatic void report_field(input string fname, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endfunction

  function automatic void restart_frame();
    col_in    = 0;
    row_in    = 0;
    out_count = 0;
  endfunction

  // Advance the window by one transfer and queue the result it completes, if any
  task automatic predict_edge(input logic [sem_pkg::PIX_W-1:0] pix_in, input logic pad_in);
    int unsigned               w, h, col, pos, k, orow, ocol;
    logic [sem_pkg::PIX_W-1:0] v, up, lo;
    int                        p [9];
    int                        gx, gy, i;
    edge_result_t              r;
    w = clamp_dim(cfg_width, sem_pkg::MAX_WIDTH);
    h = clamp_dim(cfg_height, sem_pkg::MAX_HEIGHT);
    // drop pads inside the frame; anything past the frame is a zero flush tick
    if (row_in < h) begin
      if (pad_in) return;
      v = pix_in;
    end else begin
      v = '0;
    end
    col = (col_in >= w) ? w - 1 : col_in;
    up  = upper_line[col];
    lo  = lower_line[col];
    upper_line[col] = lo;
    lower_line[col] = v;
    for (i = 0; i < 6; i++) win[i] = win[i + 3];
    win[6] = up;
    win[7] = lo;
    win[8] = v;
    pos    = row_in * w + col;
    col_in = col + 1;
    if (col_in >= w) begin
      col_in = 0;
      row_in++;
    end
    if (pos < w + 1) return;
    // zero padding around the frame border
    k    = out_count;
    orow = k / w;
    ocol = k % w;
    for (i = 0; i < 9; i++) p[i] = win[i];
    if (ocol == 0) begin
      p[0] = 0; p[1] = 0; p[2] = 0;
    end
    if (ocol == w - 1) begin
      p[6] = 0; p[7] = 0; p[8] = 0;
    end
    if (orow == 0) begin
      p[0] = 0; p[3] = 0; p[6] = 0;
    end
    if (orow == h - 1) begin
      p[2] = 0; p[5] = 0; p[8] = 0;
    end
    gx = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
    gy = (p[0] + 2 * p[3] + p[6]) - (p[2] + 2 * p[5] + p[8]);
    r.horiz = sat_u8(gx);
    r.vert  = sat_u8(gy);
    r.mag   = sat_u8((gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy));
    r.last  = 1'b0;
    out_count = k + 1;
    if (out_count >= w * h) begin
      r.last = 1'b1;
      restart_frame();
    end
    expected_edges.push_back(r);
  endtask

  // Check results and record input transfers
  always @(posedge clk) begin : monitor
    edge_result_t seen, want;
    in_taken = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen.horiz = horiz_gradient;
        seen.vert  = vert_gradient;
        seen.mag   = magnitude;
        seen.last  = frame_last;
        if (expected_edges.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                   $time, seen.horiz, seen.vert, seen.mag, seen.last);
        end else begin
          want = expected_edges.pop_front();
          report_field("horiz_gradient", want.horiz, seen.horiz);
          report_field("vert_gradient", want.vert, seen.vert);
          report_field("magnitude", want.mag, seen.mag);
          report_field("frame_last", want.last, seen.last);
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        predict_edge(pixel, is_pad);
      end
    end
  end

  // Pixel driver: present the next item once the current one has transferred
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        in_gap_left = $urandom_range(0, 2);
        in_valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        pixel    <= pending_pixels[0].pix;
        is_pad   <= pending_pixels[0].pad;
        in_valid <= 1'b1;
        void'(pending_pixels.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure in short bursts
  always @(negedge clk) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_stall <= 1'b1;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      out_stall_left = $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Hold until the stream is empty and every result has come back
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_pixels.size() != 0 || in_valid || expected_edges.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    logic [31:0] rd;
    wait_idle();
    apb_access(1'b1, {sem_pkg::REG_IMAGE_WIDTH, 2'b00}, w, rd);
    cfg_width = w[sem_pkg::WIDTH_W-1:0];
    restart_frame();
    apb_access(1'b0, {sem_pkg::REG_IMAGE_WIDTH, 2'b00}, '0, rd);
    report_field("image_width readback", cfg_width, rd);
    apb_access(1'b1, {sem_pkg::REG_IMAGE_HEIGHT, 2'b00}, h, rd);
    cfg_height = h[sem_pkg::HEIGHT_W-1:0];
    restart_frame();
    apb_access(1'b0, {sem_pkg::REG_IMAGE_HEIGHT, 2'b00}, '0, rd);
    report_field("image_height readback", cfg_height, rd);
    frame_w = clamp_dim(cfg_width, sem_pkg::MAX_WIDTH);
    frame_h = clamp_dim(cfg_height, sem_pkg::MAX_HEIGHT);
  endtask

  task automatic push_item(input logic [sem_pkg::PIX_W-1:0] pix, input logic pad);
    pixel_item_t it;
    it.pix = pix;
    it.pad = pad;
    pending_pixels.push_back(it);
    stim_count++;
  endtask

  // Bias toward black and white so gradients saturate often
  function automatic logic [sem_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 8'd255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  // Queue n pixels of the current frame with stray pads, then, if flush is set, the flush ticks
  task automatic push_frame(input int unsigned n_pix, input bit flush);
    int unsigned i;
    for (i = 0; i < n_pix; i++) begin
      if ($urandom_range(0, 9) == 0) push_item(rand_pixel(), 1'b1);
      push_item(rand_pixel(), 1'b0);
    end
    if (flush) begin
      for (i = 0; i <= frame_w; i++) push_item(rand_pixel(), $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin : stimulus
    int unsigned ext_w [9] = '{0, 1, 2, 3, 1, 7, 2, 4095, 2};
    int unsigned ext_h [9] = '{0, 2, 2, 1, 1, 0, 3, 1, 8191};
    logic [31:0] rd;
    int unsigned n, part;
    bit          paused;
    paused = 1'b0;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      lower_line[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset values of the geometry registers
    apb_access(1'b0, {sem_pkg::REG_IMAGE_WIDTH, 2'b00}, '0, rd);
    report_field("image_width reset", sem_pkg::WIDTH_RESET, rd);
    apb_access(1'b0, {sem_pkg::REG_IMAGE_HEIGHT, 2'b00}, '0, rd);
    report_field("image_height reset", sem_pkg::HEIGHT_RESET, rd);

    // 3x3 frame: hard edges, a pad inside the frame, flush ticks with and without the pad flag
    set_geometry(3, 3);
    push_item(8'd0, 1'b0);   push_item(8'd255, 1'b0); push_item(8'd0, 1'b0);
    push_item(8'd200, 1'b1);
    push_item(8'd255, 1'b0); push_item(8'd0, 1'b0);   push_item(8'd255, 1'b0);
    push_item(8'd255, 1'b0); push_item(8'd255, 1'b0); push_item(8'd255, 1'b0);
    push_item(8'd0, 1'b1);   push_item(8'd255, 1'b0); push_item(8'd17, 1'b1);
    push_item(8'd255, 1'b0);
    // single pixel frame, back to back twice
    set_geometry(1, 1);
    push_item(8'd255, 1'b0); push_item(8'd255, 1'b0); push_item(8'd0, 1'b1);
    push_item(8'd128, 1'b0); push_item(8'd0, 1'b1);   push_item(8'd255, 1'b0);

    // tiny and out-of-range geometries; oversize frames stop after 20 pixels
    foreach (ext_w[i]) begin
      set_geometry(ext_w[i], ext_h[i]);
      n = frame_w * frame_h;
      if (n > 64) push_frame(20, 1'b0);
      else push_frame(n, 1'b1);
    end

    // random geometries, several frames per setting
    while (stim_count < 600) begin
      idling = $urandom_range(0, 3) != 0;
      set_geometry($urandom_range(1, 24), $urandom_range(1, 8));
      n = frame_w * frame_h;
      if (!paused && n > 1) begin
        // stop mid-frame until the unit has drained, then carry on
        part = $urandom_range(1, n - 1);
        push_frame(part, 1'b0);
        wait_idle();
        push_frame(n - part, 1'b1);
        paused = 1'b1;
      end
      repeat ($urandom_range(1, 3)) push_frame(n, 1'b1);
      // leave a frame unfinished so the next write restarts it
      if (n > 1 && $urandom_range(0, 5) == 0) push_frame($urandom_range(1, n - 1), 1'b0);
    end

    // closing stretch at full rate
    idling = 1'b0;
    set_geometry($urandom_range(4, 16), $urandom_range(3, 6));
    repeat (2) push_frame(frame_w * frame_h, 1'b1);
    wait_idle();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
